>>> hdl/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared types, constants and arithmetic helpers for the pyramid reduce block.
// ----------------------------------------------------------------------------
package gpr_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_W       = 11;
    localparam int COORD_W     = 13;   // covers the whole MAX_WIDTH/MAX_HEIGHT range
    localparam int OUT_COORD_W = 10;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = 2;

    typedef logic [1:0]         t_cfg_idx;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [PIX_W-1:0]   t_pix;

    localparam t_cfg_idx CFG_IMAGE_WIDTH     = 2'd0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT    = 2'd1;
    localparam t_cfg_idx CFG_DECIMATE_ENABLE = 2'd2;

    // one request from the front: pixel window (index 4 = newest) and position
    typedef struct packed {
        logic [4:0][PIX_W-1:0] win;
        t_coord                col;
        t_coord                row;
        logic                  col_last;
        logic                  row_last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // (1,4,6,4,1)/16, floored
    function automatic t_pix blur5(input t_pix a, input t_pix b, input t_pix c,
                                   input t_pix d, input t_pix e);
        logic [11:0] s;
        s = {4'd0, a} + {2'd0, b, 2'd0} + {3'd0, c, 1'b0} + {2'd0, c, 2'd0}
          + {2'd0, d, 2'd0} + {4'd0, e};
        return s[11:4];
    endfunction

    // true if [lo, hi] holds an odd value
    function automatic logic has_odd(input t_coord lo, input t_coord hi);
        return (lo <= hi) && (lo[0] || (lo < hi));
    endfunction

endpackage

>>> hdl/gpr_front.sv
// ----------------------------------------------------------------------------
// gpr_front
// Config registers, raster position and raw pixel window; issues column jobs.
// ----------------------------------------------------------------------------
module gpr_front import gpr_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_pix             i_pixel,
    input  logic             i_full,
    output logic             o_push,
    output t_job             o_job,
    output logic             o_decimate
);

    logic [CFG_W-1:0] r_width, r_height;
    logic             r_decimate;
    t_coord           r_col, n_col;
    t_coord           r_row, n_row;
    logic [3:0][PIX_W-1:0] r_win;
    t_coord           w_m1, h_m1;
    logic             accept;

    always_comb begin
        if (r_width < CFG_W'(4))
            w_m1 = t_coord'(3);
        else if (32'(r_width) > MAX_WIDTH)
            w_m1 = t_coord'(MAX_WIDTH - 1);
        else
            w_m1 = t_coord'(r_width) - t_coord'(1);
        if (r_height < CFG_W'(4))
            h_m1 = t_coord'(3);
        else if (32'(r_height) > MAX_HEIGHT)
            h_m1 = t_coord'(MAX_HEIGHT - 1);
        else
            h_m1 = t_coord'(r_height) - t_coord'(1);
    end

    assign o_ready    = !i_full;
    assign accept     = i_valid && !i_full;
    assign o_decimate = r_decimate;

    assign o_job.win      = {i_pixel, r_win[3], r_win[2], r_win[1], r_win[0]};
    assign o_job.col      = r_col;
    assign o_job.row      = r_row;
    assign o_job.col_last = (r_col == w_m1);
    assign o_job.row_last = (r_row == h_m1);
    // the first two pixels of a row complete no column yet
    assign o_push         = accept && (r_col >= t_coord'(2));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (o_job.col_last) begin
                n_col = '0;
                n_row = o_job.row_last ? '0 : r_row + t_coord'(1);
            end else begin
                n_col = r_col + t_coord'(1);
            end
        end
        if (i_cfg_we && (i_cfg_idx == CFG_IMAGE_WIDTH || i_cfg_idx == CFG_IMAGE_HEIGHT)) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= CFG_W'(1024);
            r_height   <= CFG_W'(1024);
            r_decimate <= 1'b1;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:     r_width    <= i_cfg_data;
                    CFG_IMAGE_HEIGHT:    r_height   <= i_cfg_data;
                    CFG_DECIMATE_ENABLE: r_decimate <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= {i_pixel, r_win[3], r_win[2], r_win[1]};
        end
    end

endmodule

>>> hdl/gpr_queue.sv
// ----------------------------------------------------------------------------
// gpr_queue
// Short request FIFO between the front and the back.
// ----------------------------------------------------------------------------
module gpr_queue import gpr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

endmodule

>>> hdl/gpr_back.sv
// ----------------------------------------------------------------------------
// gpr_back
// Steps each request over its (column, row) pairs: row pass, line stores,
// column pass and the output register.
// ----------------------------------------------------------------------------
module gpr_back import gpr_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_job                   i_job,
    input  logic                   i_q_valid,
    output logic                   o_pop,
    input  logic                   i_decimate,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_pix                   o_pixel,
    output logic [OUT_COORD_W-1:0] o_row,
    output logic [OUT_COORD_W-1:0] o_col,
    output logic                   o_last,
    output logic                   o_frame_done
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int SW = COORD_W + 2;

    logic   r_busy;
    t_job   r_job;
    t_coord r_x, r_y, r_x1, r_y0, r_y1;
    logic   r_noemit;

    logic   en, step_last, issue, wr;
    t_coord ld_y0, ld_y1, ld_x1;
    t_pix   hv;
    logic   emit, last;
    logic [AW-1:0] addr;
    t_pix   rd_data [4];

    logic   r_s2_valid, r_s2_emit, r_s2_last, r_s2_done;
    t_pix   r_s2_hv;
    t_coord r_s2_x, r_s2_y, r_s2_row;
    t_pix   res;

    logic   r_o_valid;

    assign en        = !r_o_valid || i_ready;
    assign step_last = (r_x == r_x1) && (r_y == r_y1);
    assign o_pop     = en && (!r_busy || step_last) && i_q_valid;
    assign issue     = en && r_busy;
    // line store takes the row-pass value after the last read of its column
    assign wr        = issue && (r_y == r_y1);
    assign addr      = r_x[AW-1:0];

    always_comb begin
        ld_x1 = i_job.col_last ? i_job.col : i_job.col - t_coord'(2);
        ld_y0 = (i_job.row >= t_coord'(2)) ? i_job.row - t_coord'(2) : i_job.row;
        ld_y1 = ((i_job.row >= t_coord'(2)) && i_job.row_last) ? i_job.row : ld_y0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (en) begin
            if (o_pop)          r_busy <= 1'b1;
            else if (step_last) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (o_pop) begin
                r_job    <= i_job;
                r_x      <= i_job.col - t_coord'(2);
                r_x1     <= ld_x1;
                r_y      <= ld_y0;
                r_y0     <= ld_y0;
                r_y1     <= ld_y1;
                r_noemit <= (i_job.row < t_coord'(2));
            end else if (r_busy && !step_last) begin
                if (r_y == r_y1) begin
                    r_x <= r_x + t_coord'(1);
                    r_y <= r_y0;
                end else begin
                    r_y <= r_y + t_coord'(1);
                end
            end
        end
    end

    // row pass with mirrored borders; tap distance d from the newest pixel
    always_comb begin
        logic signed [SW-1:0] pos, m, cs, d;
        t_pix tap [5];
        cs = signed'(SW'(r_job.col));
        for (int k = 0; k < 5; k++) begin
            pos = signed'(SW'(r_x)) + SW'(k) - SW'(2);
            if (pos < 0)       m = -pos - SW'(1);
            else if (pos > cs) m = (cs <<< 1) + SW'(1) - pos;
            else               m = pos;
            d = cs - m;
            case (d[2:0])
                3'd0:    tap[k] = r_job.win[4];
                3'd1:    tap[k] = r_job.win[3];
                3'd2:    tap[k] = r_job.win[2];
                3'd3:    tap[k] = r_job.win[1];
                3'd4:    tap[k] = r_job.win[0];
                default: tap[k] = '0;
            endcase
        end
        hv = blur5(tap[0], tap[1], tap[2], tap[3], tap[4]);
    end

    // which pairs emit a result, and which one carries the final result of this request
    always_comb begin
        if (i_decimate) begin
            emit = !r_noemit && r_x[0] && r_y[0];
            last = emit && !(r_x[0] && has_odd(r_y + t_coord'(1), r_y1))
                        && !(has_odd(r_x + t_coord'(1), r_x1) && has_odd(r_y0, r_y1));
        end else begin
            emit = !r_noemit;
            last = emit && step_last;
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        t_pix mem [MAX_WIDTH];
        t_pix r_q;
        always_ff @(posedge i_clk) begin
            if (issue) r_q <= mem[addr];
            if (wr && (r_job.row[1:0] == 2'(b))) mem[addr] <= hv;
        end
        assign rd_data[b] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_hv   <= hv;
            r_s2_x    <= r_x;
            r_s2_y    <= r_y;
            r_s2_row  <= r_job.row;
            r_s2_emit <= emit;
            r_s2_last <= last;
            r_s2_done <= last && r_job.row_last && r_job.col_last;
        end
    end

    // column pass: the current row comes from the row pass, others from the stores
    always_comb begin
        logic signed [SW-1:0] i, m, rs;
        t_pix v [5];
        rs = signed'(SW'(r_s2_row));
        for (int k = 0; k < 5; k++) begin
            i = signed'(SW'(r_s2_y)) + SW'(k) - SW'(2);
            if (i < 0)       m = -i - SW'(1);
            else if (i > rs) m = (rs <<< 1) + SW'(1) - i;
            else             m = i;
            v[k] = (m == rs) ? r_s2_hv : rd_data[m[1:0]];
        end
        res = blur5(v[0], v[1], v[2], v[3], v[4]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_s2_valid && r_s2_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_pixel      <= res;
            o_row        <= i_decimate ? r_s2_y[OUT_COORD_W:1] : r_s2_y[OUT_COORD_W-1:0];
            o_col        <= i_decimate ? r_s2_x[OUT_COORD_W:1] : r_s2_x[OUT_COORD_W-1:0];
            o_last       <= r_s2_last;
            o_frame_done <= r_s2_done;
        end
    end

    assign o_valid = r_o_valid;

endmodule

>>> hdl/gaussian_pyramid_reduce_top.sv
// ----------------------------------------------------------------------------
// gaussian_pyramid_reduce_top
// 5-tap binomial blur with optional 2:1 decimation, streaming raster pixels.
// ----------------------------------------------------------------------------
// A pixel's first result passes the queue, then the back's request, stage-two and output registers.
// Throughput: one pixel per clock except on the last row and while the queue is full;
// the back runs one (column, row) pair per cycle unless the output stalls, so the
// extra pairs of a row end are absorbed by the 4-entry request queue; last-row columns carry more pairs.
// Reset: synchronous active low; 1024x1024, decimate on, position at origin.
// Line stores are not cleared; each entry is written before it is read.
module gaussian_pyramid_reduce_top import gpr_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,   // [7:0] pixel_in
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [7:0] pixel_out, [17:8] out_row, [27:18] out_col
    output logic             o_m_axis_tlast,   // last_of_run
    output logic             o_m_axis_tuser    // [0] frame_done
);

    t_job    front_job, q_job;
    t_q_stat q_stat;
    logic    push, pop, decimate;
    t_pix    pixel;
    logic [OUT_COORD_W-1:0] row, col;

    gpr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_pixel    (i_s_axis_tdata),
        .i_full     (q_stat.full),
        .o_push     (push),
        .o_job      (front_job),
        .o_decimate (decimate)
    );

    gpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    gpr_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (q_job),
        .i_q_valid    (!q_stat.empty),
        .o_pop        (pop),
        .i_decimate   (decimate),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_pixel      (pixel),
        .o_row        (row),
        .o_col        (col),
        .o_last       (o_m_axis_tlast),
        .o_frame_done (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {4'd0, col, row, pixel};

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("frame_done without last_of_run");

    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("request popped from empty queue");

endmodule

>>> verif/gpr_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpr_scoreboard
// Watches the register port and both streams of the pyramid reduce block. It
// keeps its own copy of the blur state, predicts each result and compares.
// ----------------------------------------------------------------------------
module gpr_scoreboard import gpr_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_s_axis_tvalid,
    input  logic             i_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,
    input  logic             i_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    input  logic [31:0]      i_m_axis_tdata,
    input  logic             i_m_axis_tlast,
    input  logic             i_m_axis_tuser,
    output int               o_errors,
    output int               o_pending,
    output int               o_checked
);

    typedef struct {
        logic [7:0] pix;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
        logic       done;
    } t_blur_result;

    logic [CFG_W-1:0] img_w, img_h;
    logic             decim;
    logic [7:0]       raw_hist [0:3];
    logic [7:0]       line_mem [0:3][0:MAX_WIDTH-1];
    int               row_pos, col_pos;
    t_blur_result     expected_q[$];
    int               errors = 0;
    int               checked = 0;

    assign o_errors  = errors;
    assign o_pending = expected_q.size();
    assign o_checked = checked;

    function automatic int clampv(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // edge pixel repeated: -1 -> 0, -2 -> 1, n -> n-1, n+1 -> n-2
    function automatic int fold_index(input int i, input int n);
        if (i < 0) return -1 - i;
        if (i >= n) return 2 * n - 1 - i;
        return i;
    endfunction

    function automatic int binomial5(input int a, input int b, input int c,
                                     input int d, input int e);
        return (a + 4 * b + 6 * c + 4 * d + e) >> 4;
    endfunction

    function automatic void predict_pixel(input logic [7:0] p);
        int w, h, c, r, xf, xl, yf, yl, d, k, hv, res;
        int t[5];
        int v[5];
        t_blur_result run_q[$];
        t_blur_result it;
        w  = clampv(int'(img_w), 4, MAX_WIDTH);
        h  = clampv(int'(img_h), 4, MAX_HEIGHT);
        c  = clampv(col_pos, 0, w - 1);
        r  = clampv(row_pos, 0, h - 1);
        xf = (c >= 2) ? c - 2 : c + 1;
        xl = (c == w - 1) ? c : c - 2;
        yf = (r >= 2) ? r - 2 : r + 1;
        yl = (r == h - 1) ? r : r - 2;
        for (int x = xf; x <= xl; x++) begin
            for (k = 0; k < 5; k++) begin
                d = c - fold_index(x + k - 2, w);
                if (d == 0) t[k] = p;
                else if (d >= 1 && d <= 4) t[k] = raw_hist[4 - d];
                else t[k] = 0;
            end
            hv = binomial5(t[0], t[1], t[2], t[3], t[4]);
            for (int y = yf; y <= yl; y++) begin
                for (k = 0; k < 5; k++) begin
                    d = fold_index(y + k - 2, h);
                    v[k] = (d == r) ? hv : line_mem[d & 3][x];
                end
                res = binomial5(v[0], v[1], v[2], v[3], v[4]);
                if (!decim || ((y & 1) && (x & 1))) begin
                    it.pix  = res[7:0];
                    it.row  = decim ? 10'(y >> 1) : 10'(y);
                    it.col  = decim ? 10'(x >> 1) : 10'(x);
                    it.last = 1'b0;
                    it.done = 1'b0;
                    run_q = {run_q, it};
                end
            end
            line_mem[r & 3][x] = hv[7:0];
        end
        raw_hist[0] = raw_hist[1];
        raw_hist[1] = raw_hist[2];
        raw_hist[2] = raw_hist[3];
        raw_hist[3] = p;
        if (run_q.size() > 0) begin
            run_q[$].last = 1'b1;
            run_q[$].done = (r == h - 1) && (c == w - 1);
        end
        expected_q = {expected_q, run_q};
        if (c == w - 1) begin
            col_pos = 0;
            row_pos = (r == h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_blur_result e;
        if (!i_rst_n) begin
            img_w   = 11'd1024;
            img_h   = 11'd1024;
            decim   = 1'b1;
            row_pos = 0;
            col_pos = 0;
            for (int k = 0; k < 4; k++) raw_hist[k] = 8'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMAGE_WIDTH: begin
                        img_w = i_cfg_data;
                        row_pos = 0;
                        col_pos = 0;
                    end
                    CFG_IMAGE_HEIGHT: begin
                        img_h = i_cfg_data;
                        row_pos = 0;
                        col_pos = 0;
                    end
                    CFG_DECIMATE_ENABLE: begin
                        decim = i_cfg_data[0];
                    end
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) predict_pixel(i_s_axis_tdata);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result, pixel", -1, i_m_axis_tdata[7:0]);
                end else begin
                    e = expected_q.pop_front();
                    checked++;
                    if (i_m_axis_tdata[7:0] !== e.pix)
                        report_mismatch("pixel_out", e.pix, i_m_axis_tdata[7:0]);
                    if (i_m_axis_tdata[17:8] !== e.row)
                        report_mismatch("out_row", e.row, i_m_axis_tdata[17:8]);
                    if (i_m_axis_tdata[27:18] !== e.col)
                        report_mismatch("out_col", e.col, i_m_axis_tdata[27:18]);
                    if (i_m_axis_tdata[31:28] !== 4'd0)
                        report_mismatch("tdata pad", 0, i_m_axis_tdata[31:28]);
                    if (i_m_axis_tlast !== e.last)
                        report_mismatch("last_of_run", e.last, i_m_axis_tlast);
                    if (i_m_axis_tuser !== e.done)
                        report_mismatch("frame_done", e.done, i_m_axis_tuser);
                end
            end
        end
    end

endmodule

>>> verif/gaussian_pyramid_reduce_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_pyramid_reduce_top_tb
// Drives pixel frames of many geometries through the pyramid reduce block,
// with directed border and clamp cases, random frames, idling and back
// pressure; the scoreboard checks every result.
// ----------------------------------------------------------------------------
module gaussian_pyramid_reduce_top_tb;
    import gpr_pkg::*;

    localparam int WDOG_LIMIT  = 3000;
    localparam int DRAIN_CYC   = 20;
    localparam int RAND_BUDGET = 24;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    t_cfg_idx         cfg_idx = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_data = 8'd0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [31:0]      m_data;
    logic             m_last;
    logic             m_user;

    int errors, pending, checked;
    int idle_mode = 0;      // 0 none, 1 sender, 2 receiver, 3 both
    int hold_off_req = 0;   // receiver hold length requested by stimulus
    int pixels_sent = 0;
    int setups = 0;
    int wdog = 0;

    always #5 i_clk = ~i_clk;

    gaussian_pyramid_reduce_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user)
    );

    gpr_scoreboard i_scoreboard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tlast  (m_last),
        .i_m_axis_tuser  (m_user),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // receiver: random stalls per idle mode, plus long hold-offs on request
    always @(posedge i_clk) begin
        int hold_cnt;
        if (hold_off_req > 0) begin
            hold_cnt = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else if (idle_mode == 2) begin
            m_ready <= ($urandom_range(99) >= 46);
        end else if (idle_mode == 3) begin
            m_ready <= ($urandom_range(99) >= 37);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("watchdog expired, %0d results still pending", pending);
            $display("gaussian_pyramid_reduce_top_tb: errors");
            $finish;
        end
    end

    // each cycle the sender may idle with the phase's probability
    task automatic send_pixel(input logic [7:0] p);
        int idle_pct;
        idle_pct = (idle_mode == 1) ? 46 : ((idle_mode == 3) ? 37 : 0);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge i_clk); while (!s_ready);
        pixels_sent++;
    endtask

    // block idle: nothing queued, then cover a request still inside the pipe
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_geometry(input int w, input int h, input int dec);
        settle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_DECIMATE_ENABLE, dec);
        setups++;
    endtask

    initial begin
        int w, h, n, cut, flip, rand_pixels;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: smallest frame, full output, extreme values and borders
        set_geometry(4, 4, 0);
        idle_mode = 0;
        for (int i = 0; i < 16; i++)
            send_pixel((i % 3 == 0) ? 8'd255 : ((i % 3 == 1) ? 8'd0 : 8'(i * 17)));
        // same geometry decimated
        set_geometry(4, 4, 1);
        idle_mode = 1;
        for (int i = 0; i < 16; i++) send_pixel((i & 1) ? 8'd255 : 8'd0);
        // out-of-range geometry clamps: width 0 -> 4, height 2047 -> max
        set_geometry(0, 2047, 0);
        idle_mode = 2;
        for (int i = 0; i < 12; i++) send_pixel(8'(i * 23));
        // width 2047 clamps to max; partial row, then restart by geometry write
        set_geometry(2047, 3, 1);
        idle_mode = 3;
        for (int i = 0; i < 10; i++) send_pixel(8'(255 - i));

        // back pressure: receiver holds off while the sender keeps offering
        set_geometry(8, 4, 0);
        idle_mode = 0;
        hold_off_req = 120;
        for (int i = 0; i < 32; i++) send_pixel(8'($urandom));

        rand_pixels = 0;
        while (rand_pixels < RAND_BUDGET) begin
            w = ($urandom_range(5) == 0) ? $urandom_range(7, 12) : $urandom_range(4, 6);
            h = $urandom_range(4, 6);
            set_geometry(w, h, $urandom_range(1));
            idle_mode = setups % 4;
            n    = w * h;
            cut  = ($urandom_range(5) == 0) ? $urandom_range(1, n - 1) : n;
            flip = ($urandom_range(3) == 0) ? $urandom_range(1, n - 1) : -1;
            for (int i = 0; i < cut && rand_pixels < RAND_BUDGET; i++) begin
                if (i == flip) begin
                    // decimate change mid-frame, block idle
                    settle();
                    write_reg(CFG_DECIMATE_ENABLE, $urandom_range(1));
                end
                send_pixel(8'($urandom));
                rand_pixels++;
            end
        end
        idle_mode = 0;
        settle();

        $display("covered %0d pixels across %0d geometry setups, %0d results checked",
                 pixels_sent, setups, checked);
        $display("directed borders, clamped geometry, mid-frame decimate and a long stall");
        if (errors == 0) begin
            $display("gaussian_pyramid_reduce_top_tb: clean");
        end else begin
            $display("gaussian_pyramid_reduce_top_tb: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/gpr_pkg.sv
hdl/gpr_front.sv
hdl/gpr_queue.sv
hdl/gpr_back.sv
hdl/gaussian_pyramid_reduce_top.sv
verif/gpr_scoreboard.sv
verif/gaussian_pyramid_reduce_top_tb.sv
